// File: rtl/dsp_pkg.sv
// Shared types and codes for the duplicate-rejecting stack pair.
package dsp_pkg;

	// Request kinds carried on the input channel
	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_LIST = 2'd2;
	localparam logic [1:0] REQ_ODD  = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_DUP    = 3'd2;
	localparam logic [2:0] ST_EMPTY  = 3'd3;
	localparam logic [2:0] ST_BADSEL = 3'd4;

	// Scan index operations
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_TOP,
		IDX_BELOW_TOP,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	// Source of an emitted result
	typedef enum logic [1:0] {
		EM_CODE,
		EM_POP,
		EM_LIST,
		EM_ODD
	} emit_src_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic      capture;
		idx_op_t   idx_op;
		logic      rd_en;
		logic      do_push;
		logic      do_pop;
		logic      load_top;
		logic      clr_odd;
		logic      mark_odd;
		logic      emit;
		emit_src_t emit_src;
		logic [2:0] code;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] req;
		logic       sel;
		logic       n_zero;
		logic       n_full;
		logic       n_one;
		logic       idx_zero;
		logic       idx_last;
		logic       match;
		logic       odd;
		logic       any_odd;
		logic       at_last_odd;
		logic       out_free;
	} sts_t;

endpackage

// File: rtl/dsp_ctrl.sv
// Request sequencer for the duplicate-rejecting stack pair.
module dsp_ctrl
	import dsp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_PUSH_WR,
		S_POP_RD,
		S_POP_TOP,
		S_POP_EMIT,
		S_LIST_RD,
		S_LIST_EMIT,
		S_ODD1_RD,
		S_ODD1_CMP,
		S_ODD1_END,
		S_ODD2_RD,
		S_ODD2_CMP,
		S_EMIT
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;

	// Hold state and the pending status code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		cmd          = '0;
		cmd.idx_op   = IDX_HOLD;
		cmd.emit_src = EM_CODE;
		cmd.code     = code_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (sts.req)
					REQ_PUSH: begin
						if (sts.n_full) begin
							code_d  = ST_FULL;
							state_d = S_EMIT;
						end else if (sts.n_zero) begin
							state_d = S_PUSH_WR;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_PUSH_RD;
						end
					end
					REQ_POP: begin
						if (sts.sel) begin
							code_d  = ST_BADSEL;
							state_d = S_EMIT;
						end else if (sts.n_zero) begin
							code_d  = ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.do_pop = 1'b1;
							cmd.idx_op = IDX_BELOW_TOP;
							state_d    = sts.n_one ? S_POP_EMIT : S_POP_RD;
						end
					end
					REQ_LIST: begin
						if (sts.n_zero) begin
							code_d  = ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.idx_op = IDX_TOP;
							state_d    = S_LIST_RD;
						end
					end
					default: begin
						if (sts.n_zero) begin
							code_d  = ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.idx_op  = IDX_ZERO;
							cmd.clr_odd = 1'b1;
							state_d     = S_ODD1_RD;
						end
					end
				endcase
			end
			// Duplicate scan over stored entries, bottom up
			S_PUSH_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_PUSH_CMP;
			end
			S_PUSH_CMP: begin
				if (sts.match) begin
					code_d  = ST_DUP;
					state_d = S_EMIT;
				end else if (sts.idx_last) begin
					state_d = S_PUSH_WR;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_PUSH_RD;
				end
			end
			S_PUSH_WR: begin
				cmd.do_push = 1'b1;
				code_d      = ST_OK;
				state_d     = S_EMIT;
			end
			// Refresh the top register after a pop
			S_POP_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_POP_TOP;
			end
			S_POP_TOP: begin
				cmd.load_top = 1'b1;
				state_d      = S_POP_EMIT;
			end
			S_POP_EMIT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = EM_POP;
					state_d      = S_IDLE;
				end
			end
			// Walk entries top to bottom
			S_LIST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LIST_EMIT;
			end
			S_LIST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = EM_LIST;
					if (sts.idx_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_DEC;
						state_d    = S_LIST_RD;
					end
				end
			end
			// First pass: locate the highest odd entry
			S_ODD1_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_ODD1_CMP;
			end
			S_ODD1_CMP: begin
				cmd.mark_odd = 1'b1;
				if (sts.idx_last) begin
					state_d = S_ODD1_END;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_ODD1_RD;
				end
			end
			S_ODD1_END: begin
				if (!sts.any_odd) begin
					code_d  = ST_EMPTY;
					state_d = S_EMIT;
				end else begin
					cmd.idx_op = IDX_ZERO;
					state_d    = S_ODD2_RD;
				end
			end
			// Second pass: emit odd entries, bottom up
			S_ODD2_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_ODD2_CMP;
			end
			S_ODD2_CMP: begin
				if (!sts.odd) begin
					cmd.idx_op = IDX_INC;
					state_d    = S_ODD2_RD;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = EM_ODD;
					if (sts.at_last_odd) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d    = S_ODD2_RD;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/dsp_datapath.sv
// Stack storage, counts, scan index and result register.
module dsp_datapath
	import dsp_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  in_req,
	input  logic        in_sel,
	input  logic [31:0] in_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic [31:0] out_data,
	output logic [3:0]  out_depth,
	output logic [31:0] out_peek,
	output logic        out_last
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   mem_q [2][DEPTH];
	logic [CW-1:0] cnt_q [2];
	logic [1:0]    req_q;
	logic          sel_q;
	logic [31:0]   val_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] last_odd_q;
	logic          any_odd_q;
	logic [31:0]   rdata_q;
	logic [31:0]   top_q;
	logic [31:0]   pop_data_q;
	logic          out_valid_q;
	logic [2:0]    o_status_q;
	logic [31:0]   o_data_q;
	logic [3:0]    o_depth_q;
	logic [31:0]   o_peek_q;
	logic          o_last_q;
	logic [CW-1:0] n;
	logic [31:0]   peek;
	logic          out_free;

	assign n        = cnt_q[sel_q];
	assign peek     = (cnt_q[0] != '0) ? top_q : 32'd0;
	assign out_free = !out_valid_q || out_ready;

	// Status back to the controller
	always_comb begin
		sts.req         = req_q;
		sts.sel         = sel_q;
		sts.n_zero      = (n == '0);
		sts.n_full      = (n >= CW'(DEPTH));
		sts.n_one       = (n == CW'(1));
		sts.idx_zero    = (idx_q == '0);
		sts.idx_last    = (CW'(idx_q) == n - CW'(1));
		sts.match       = (rdata_q == val_q);
		sts.odd         = rdata_q[0];
		sts.any_odd     = any_odd_q;
		sts.at_last_odd = (idx_q == last_odd_q);
		sts.out_free    = out_free;
	end

	// Capture request, step the scan index, track odd entries
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_req;
			sel_q <= in_sel;
			val_q <= in_value;
		end
		case (cmd.idx_op)
			IDX_ZERO:      idx_q <= '0;
			IDX_TOP:       idx_q <= IW'(n - CW'(1));
			IDX_BELOW_TOP: idx_q <= IW'(n - CW'(2));
			IDX_INC:       idx_q <= idx_q + IW'(1);
			IDX_DEC:       idx_q <= idx_q - IW'(1);
			default:       idx_q <= idx_q;
		endcase
		if (cmd.mark_odd && rdata_q[0]) begin
			last_odd_q <= idx_q;
		end
	end

	// Flag whether any odd entry was seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_odd_q <= 1'b0;
		end else if (cmd.clr_odd) begin
			any_odd_q <= 1'b0;
		end else if (cmd.mark_odd && rdata_q[0]) begin
			any_odd_q <= 1'b1;
		end
	end

	// Stack memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.do_push) begin
			mem_q[sel_q][IW'(n)] <= val_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[sel_q][idx_q];
		end
	end

	// Top of stack one and the popped value
	always_ff @(posedge clk) begin
		if (cmd.do_push && !sel_q) begin
			top_q <= val_q;
		end else if (cmd.load_top) begin
			top_q <= rdata_q;
		end
		if (cmd.do_pop) begin
			pop_data_q <= top_q;
		end
	end

	// Entry counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (cmd.do_push) begin
			cnt_q[sel_q] <= n + CW'(1);
		end else if (cmd.do_pop) begin
			cnt_q[0] <= cnt_q[0] - CW'(1);
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load a result transfer
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_depth_q <= 4'(cnt_q[0]);
			o_peek_q  <= peek;
			case (cmd.emit_src)
				EM_POP: begin
					o_status_q <= ST_OK;
					o_data_q   <= pop_data_q;
					o_last_q   <= 1'b1;
				end
				EM_LIST: begin
					o_status_q <= ST_OK;
					o_data_q   <= rdata_q;
					o_last_q   <= (idx_q == '0);
				end
				EM_ODD: begin
					o_status_q <= ST_OK;
					o_data_q   <= rdata_q;
					o_last_q   <= (idx_q == last_odd_q);
				end
				default: begin
					o_status_q <= cmd.code;
					o_data_q   <= 32'd0;
					o_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = o_status_q;
	assign out_data   = o_data_q;
	assign out_depth  = o_depth_q;
	assign out_peek   = o_peek_q;
	assign out_last   = o_last_q;

endmodule

// File: rtl/dedup_stack_pair_core.sv
// Top level of the duplicate-rejecting stack pair.
//
// Requests arrive on the s_ channel: tuser carries the kind (push, pop, list
// top to bottom, list odd entries) and the stack select, tdata the value.
// Results leave on the m_ channel, one transfer each; tlast marks the final
// result of a request. Every result also shows stack one's count and top.
// One request is worked at a time: the next is taken once the last result
// of the current one has been loaded into the output register.
// A push scans the selected stack for a duplicate, bottom up, with a memory
// read then a compare for each entry; a push into a full stack is refused
// without a scan. A pop refreshes the top register with a memory read when
// an entry is left below the popped one. A list walks the entries top to
// bottom; an odd request first locates the highest odd entry, then emits.
// Reset clears both counts and the output valid flag; stack contents are not
// cleared and are only read below the count. When the receiver stalls, the
// output register holds its transfer and the sequencer waits before the
// next result, so no result is lost or repeated.
module dedup_stack_pair_core
	import dsp_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [2:0]  s_tuser,  // [1:0] req_type, [2] stack_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [2:0] status, [34:3] data_out, [38:35] depth_one,
	                              // [70:39] peek_value, [71] zero
	output logic        m_tlast
);

	cmd_t        cmd;
	sts_t        sts;
	logic [2:0]  status;
	logic [31:0] data_out;
	logic [3:0]  depth_one;
	logic [31:0] peek_value;

	dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsp_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_req     (s_tuser[1:0]),
		.in_sel     (s_tuser[2]),
		.in_value   (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_data   (data_out),
		.out_depth  (depth_one),
		.out_peek   (peek_value),
		.out_last   (m_tlast)
	);

	// Pack result fields, lowest first
	assign m_tdata = {1'b0, peek_value, depth_one, data_out, status};

endmodule

// File: test/tb_dedup_stack_pair_core.sv
// Self-checking testbench for the duplicate-rejecting stack pair core.
`timescale 1ns / 100ps

module tb_dedup_stack_pair_core
	import dsp_pkg::*;
();

	localparam int          DEPTH      = 8;
	localparam int          DIR_N      = 25;
	localparam int          RAND_N     = 75;
	localparam int unsigned TAIL       = 60;
	localparam int unsigned STALL_LONG = 300;
	localparam int unsigned IDLE_LIMIT = 3000;

	// One expected output transfer
	typedef struct {
		logic [2:0]  status;
		logic [31:0] data;
		logic [3:0]  depth;
		logic [31:0] peek;
		logic        last;
	} stack_result_t;

	// One row of the directed table; typed rows carry a hand-written status and data
	typedef struct packed {
		logic [1:0]  kind;
		logic        sel;
		logic [31:0] val;
		logic        typed;
		logic [2:0]  t_status;
		logic [31:0] t_data;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_N] = '{
		// empty stacks straight after reset
		'{REQ_POP,  1'b0, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0},
		'{REQ_POP,  1'b1, 32'h0000_0000, 1'b1, ST_BADSEL, 32'h0},
		'{REQ_LIST, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,  32'h0},
		'{REQ_ODD,  1'b1, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0},
		// extremes of the value, then a duplicate of the lowest
		'{REQ_PUSH, 1'b0, 32'h8000_0000, 1'b1, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h7FFF_FFFF, 1'b1, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h8000_0000, 1'b1, ST_DUP,    32'h0},
		'{REQ_PUSH, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h0000_0000, 1'b0, ST_OK,     32'h0},
		// negative odd entries count as odd
		'{REQ_ODD,  1'b0, 32'h0000_0000, 1'b0, ST_OK,     32'h0},
		'{REQ_LIST, 1'b0, 32'h0000_0000, 1'b0, ST_OK,     32'h0},
		// fill stack one, then push into the full stack
		'{REQ_PUSH, 1'b0, 32'h0000_0002, 1'b0, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h0000_0004, 1'b0, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h0000_0006, 1'b0, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h0000_0008, 1'b0, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b0, 32'h0000_0000, 1'b1, ST_FULL,   32'h0},
		'{REQ_PUSH, 1'b0, 32'h1234_5678, 1'b1, ST_FULL,   32'h0},
		'{REQ_POP,  1'b0, 32'h0000_0000, 1'b0, ST_OK,     32'h0},
		// stack two: no odd entry while not empty, duplicate, listing
		'{REQ_PUSH, 1'b1, 32'h0000_0002, 1'b1, ST_OK,     32'h0},
		'{REQ_ODD,  1'b1, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0},
		'{REQ_PUSH, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,     32'h0},
		'{REQ_PUSH, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_DUP,    32'h0},
		'{REQ_LIST, 1'b1, 32'h0000_0000, 1'b0, ST_OK,     32'h0},
		'{REQ_ODD,  1'b1, 32'h0000_0000, 1'b0, ST_OK,     32'h0},
		'{REQ_POP,  1'b1, 32'h0000_0000, 1'b1, ST_BADSEL, 32'h0}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = 32'h0;
	logic [2:0]  s_tuser  = 3'h0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [71:0] m_tdata;
	logic        m_tlast;

	// Shadow copy of both stacks
	logic [31:0] shadow_one [DEPTH];
	logic [31:0] shadow_two [DEPTH];
	int unsigned shadow_fill_one = 0;
	int unsigned shadow_fill_two = 0;

	stack_result_t pending_results [$];
	int unsigned   mismatches  = 0;
	int unsigned   reqs_taken  = 0;
	int unsigned   idle_cycles = 0;

	always #5 clk = ~clk;

	dedup_stack_pair_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// Build a result; depth and top of stack one as they stand now
	function automatic stack_result_t shape_result(logic [2:0] st, logic [31:0] d, logic fin);
		stack_result_t r;
		r.status = st;
		r.data   = d;
		r.depth  = 4'(shadow_fill_one);
		r.peek   = (shadow_fill_one != 0) ? shadow_one[shadow_fill_one - 1] : 32'h0;
		r.last   = fin;
		return r;
	endfunction

	// Apply one request to the shadow stacks and queue the results it causes
	function automatic void predict_stack_request(logic [1:0] kind, logic sel,
	                                              logic [31:0] val);
		logic [31:0] entries [DEPTH];
		int unsigned n;
		int unsigned top_odd;
		logic        found;
		if (sel) begin
			entries = shadow_two;
			n       = shadow_fill_two;
		end else begin
			entries = shadow_one;
			n       = shadow_fill_one;
		end
		found   = 1'b0;
		top_odd = 0;
		case (kind)
		REQ_PUSH: begin
			for (int i = 0; i < n; i++)
				if (entries[i] == val)
					found = 1'b1;
			if (n >= DEPTH)
				pending_results.push_back(shape_result(ST_FULL, 32'h0, 1'b1));
			else if (found)
				pending_results.push_back(shape_result(ST_DUP, 32'h0, 1'b1));
			else begin
				if (sel) begin
					shadow_two[n]   = val;
					shadow_fill_two = n + 1;
				end else begin
					shadow_one[n]   = val;
					shadow_fill_one = n + 1;
				end
				pending_results.push_back(shape_result(ST_OK, 32'h0, 1'b1));
			end
		end
		REQ_POP: begin
			if (sel)
				pending_results.push_back(shape_result(ST_BADSEL, 32'h0, 1'b1));
			else if (n == 0)
				pending_results.push_back(shape_result(ST_EMPTY, 32'h0, 1'b1));
			else begin
				shadow_fill_one = n - 1;
				pending_results.push_back(shape_result(ST_OK, shadow_one[n - 1], 1'b1));
			end
		end
		REQ_LIST: begin
			if (n == 0)
				pending_results.push_back(shape_result(ST_EMPTY, 32'h0, 1'b1));
			else
				for (int i = int'(n) - 1; i >= 0; i--)
					pending_results.push_back(shape_result(ST_OK, entries[i], i == 0));
		end
		default: begin
			// odd entries, bottom to top
			for (int i = 0; i < n; i++)
				if (entries[i][0]) begin
					found   = 1'b1;
					top_odd = i;
				end
			if (!found)
				pending_results.push_back(shape_result(ST_EMPTY, 32'h0, 1'b1));
			else
				for (int i = 0; i < n; i++)
					if (entries[i][0])
						pending_results.push_back(shape_result(ST_OK, entries[i], i == top_odd));
		end
		endcase
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request and hold it until the transfer
	task automatic offer_request(input logic [1:0] kind, input logic sel, input logic [31:0] val);
		s_tvalid <= 1'b1;
		s_tuser  <= {sel, kind};
		s_tdata  <= val;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drop valid for a while, with noise on the idle bus
	task automatic hold_off_sender(input int unsigned cycles);
		s_tvalid <= 1'b0;
		s_tuser  <= 3'($urandom);
		s_tdata  <= $urandom;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Pause the sender until every expected result has come, then let the block settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL)
			@(posedge clk);
	endtask

	// Predict on input transfers, check output transfers, watch for a hang
	always @(posedge clk) begin : scoreboard
		stack_result_t want;
		int unsigned   base;
		if (s_tvalid && s_tready) begin
			base = pending_results.size();
			predict_stack_request(s_tuser[1:0], s_tuser[2], s_tdata);
			if (reqs_taken < DIR_N && DIRECTED[reqs_taken].typed) begin
				pending_results[base].status = DIRECTED[reqs_taken].t_status;
				pending_results[base].data   = DIRECTED[reqs_taken].t_data;
			end
			reqs_taken++;
		end
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tdata=%h last=%b", m_tdata, m_tlast);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[2:0] !== want.status || m_tdata[34:3] !== want.data ||
				    m_tdata[38:35] !== want.depth || m_tdata[70:39] !== want.peek ||
				    m_tdata[71] !== 1'b0 || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp st=%0d data=%h depth=%0d peek=%h last=%b",
							want.status, want.data, want.depth, want.peek, want.last);
						$display("          got st=%0d data=%h depth=%0d peek=%h last=%b pad=%b",
							m_tdata[2:0], m_tdata[34:3], m_tdata[38:35], m_tdata[70:39],
							m_tlast, m_tdata[71]);
					end
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stalls, calm stretches, and one long hold-off
	initial begin : result_sink
		int unsigned taken;
		logic        held_long;
		taken     = 0;
		held_long = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				taken++;
			if (!held_long && taken >= 60) begin
				held_long = 1'b1;
				m_tready <= 1'b0;
				repeat (STALL_LONG)
					@(posedge clk);
				m_tready <= 1'b1;
			end else if ((taken / 24) % 3 != 2 && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap())
					@(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Request side: reset, directed table, then random requests
	initial begin : request_source
		logic [1:0]  kind;
		logic        sel;
		logic [31:0] val;
		int unsigned r;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		for (int k = 0; k < DIR_N; k++) begin
			if (k % 4 == 3)
				hold_off_sender(pick_gap());
			offer_request(DIRECTED[k].kind, DIRECTED[k].sel, DIRECTED[k].val);
		end
		drain_results();

		// random requests; small values so that duplicates are common
		for (int k = 0; k < RAND_N; k++) begin
			if (k == RAND_N / 2)
				drain_results();
			else if ((k / 16) % 3 != 1 && $urandom_range(0, 1) == 1)
				hold_off_sender(pick_gap());
			r = $urandom_range(0, 99);
			if (r < 40)
				kind = REQ_PUSH;
			else if (r < 65)
				kind = REQ_POP;
			else if (r < 80)
				kind = REQ_LIST;
			else
				kind = REQ_ODD;
			sel = (kind == REQ_POP) ? ($urandom_range(0, 4) == 0) : 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 45)
				val = 32'($urandom_range(0, 11)) - 32'd6;
			else if (r < 55)
				val = r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else
				val = $urandom;
			offer_request(kind, sel, val);
		end
		drain_results();

		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
